### hdl/vpw_rx_pkg.sv
// Shared types and codes for the VPW frame receiver.
// No dependencies; imported by vpw_rx_core and vpw_frame_receiver.
package vpw_rx_pkg;

  // Result kinds, carried on the master-side tuser
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_NODATA = 2'd2;
  localparam logic [1:0] KIND_BUSERR = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_RESP_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_START_MIN    = 3'd1;
  localparam logic [2:0] REG_START_MAX    = 3'd2;
  localparam logic [2:0] REG_PULSE_MIN    = 3'd3;
  localparam logic [2:0] REG_SHORT_MAX    = 3'd4;
  localparam logic [2:0] REG_LONG_MIN     = 3'd5;
  localparam logic [2:0] REG_LONG_MAX     = 3'd6;
  localparam logic [2:0] REG_END_MIN      = 3'd7;

  localparam logic [4:0] LIMIT_TWELVE = 5'd12;

  typedef struct packed {
    logic [15:0] resp_timeout;
    logic [15:0] start_min;
    logic [15:0] start_max;
    logic [15:0] pulse_min;
    logic [15:0] short_max;
    logic [15:0] long_min;
    logic [15:0] long_max;
    logic [15:0] end_min;
  } cfg_t;

  typedef struct packed {
    logic       bus_active;
    logic       arm;
    logic       limit_to_twelve;
  } sample_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [4:0] frame_bytes;
  } result_t;

endpackage

### hdl/vpw_rx_core.sv
// Pulse width decoder: frame state registers and the per-tick decode logic.
// Depends on vpw_rx_pkg.
module vpw_rx_core import vpw_rx_pkg::*; #(
  parameter int BUFFER_BYTES = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_SOF  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  localparam logic [4:0] BUF_LIMIT = 5'(BUFFER_BYTES);

  logic [1:0]  phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic        last_q, last_d;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  bits_q, bits_d;
  logic [4:0]  bytes_q, bytes_d;
  logic [4:0]  limit_q, limit_d;

  // state as seen after an arm request clears the frame
  logic [1:0]  ph;
  logic [15:0] tc, tc_inc;
  logic        ll, bit_val;
  logic [7:0]  sb, shift_n;
  logic [3:0]  bl, bits_n;
  logic [4:0]  bd, lim;

  always_comb begin
    ph      = sample_i.arm ? PH_WAIT : phase_q;
    tc      = sample_i.arm ? 16'd0 : tick_q;
    ll      = sample_i.arm ? 1'b0 : last_q;
    sb      = sample_i.arm ? 8'd0 : shift_q;
    bl      = sample_i.arm ? 4'd8 : bits_q;
    bd      = sample_i.arm ? 5'd0 : bytes_q;
    lim     = limit_q;
    if (sample_i.arm) begin
      lim = (sample_i.limit_to_twelve && (LIMIT_TWELVE < BUF_LIMIT)) ? LIMIT_TWELVE : BUF_LIMIT;
    end
    tc_inc  = (tc == 16'hFFFF) ? tc : tc + 16'd1;
    bit_val = 1'b0;
    shift_n = sb;
    bits_n  = bl;

    phase_d = ph;
    tick_d  = tc;
    last_d  = ll;
    shift_d = sb;
    bits_d  = bl;
    bytes_d = bd;
    limit_d = lim;

    res_o.valid       = 1'b0;
    res_o.kind        = KIND_BYTE;
    res_o.data_byte   = 8'd0;
    res_o.frame_bytes = bd;

    case (ph)
      PH_WAIT: begin
        if (sample_i.bus_active) begin
          phase_d = PH_SOF;
          tick_d  = 16'd1;
          if (16'd1 >= cfg_i.start_max) begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_BUSERR;
          end
        end else begin
          tick_d = tc_inc;
          if (tc_inc >= cfg_i.resp_timeout) begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_NODATA;
          end
        end
      end
      PH_SOF: begin
        if (sample_i.bus_active) begin
          tick_d = tc_inc;
          if (tc_inc >= cfg_i.start_max) begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_BUSERR;
          end
        end else if (tc < cfg_i.start_min) begin
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_BUSERR;
        end else begin
          phase_d = PH_DATA;
          last_d  = 1'b0;
          tick_d  = 16'd1;
        end
      end
      PH_DATA: begin
        if (bd >= lim) begin
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_END;
        end else if (sample_i.bus_active == ll) begin
          tick_d = tc_inc;
          if (tc_inc >= cfg_i.end_min) begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_END;
          end
        end else begin
          last_d = sample_i.bus_active;
          tick_d = 16'd1;
          if (tc < cfg_i.pulse_min) begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_BUSERR;
          end else begin
            // short active pulse or long passive pulse -> 1
            bit_val = ((tc < cfg_i.short_max) && !sample_i.bus_active) ||
                      ((tc > cfg_i.long_min) && (tc < cfg_i.long_max) && sample_i.bus_active);
            shift_n = {sb[6:0], bit_val};
            bits_n  = bl - 4'd1;
            if (bits_n == 4'd0) begin
              bits_d            = 4'd8;
              shift_d           = 8'd0;
              bytes_d           = bd + 5'd1;
              res_o.valid       = 1'b1;
              res_o.kind        = KIND_BYTE;
              res_o.data_byte   = shift_n;
              res_o.frame_bytes = bd + 5'd1;
            end else begin
              shift_d = shift_n;
              bits_d  = bits_n;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 16'd0;
      last_q  <= 1'b0;
      shift_q <= 8'd0;
      bits_q  <= 4'd8;
      bytes_q <= 5'd0;
      limit_q <= BUF_LIMIT;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      last_q  <= last_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      bytes_q <= bytes_d;
      limit_q <= limit_d;
    end
  end

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bits_q != 4'd0) && (bits_q <= 4'd8))
    else $error("bit counter out of range");

  a_bytes_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= limit_q)
    else $error("byte count passed the frame limit");

  a_byte_stays_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid && (res_o.kind == KIND_BYTE)) |=> (phase_q == PH_DATA))
    else $error("left data phase on a completed byte");

endmodule

### hdl/vpw_frame_receiver.sv
// VPW frame receiver top level: stream handshakes, config registers, result register.
// Depends on vpw_rx_pkg and vpw_rx_core.
//
// Usage: one request on the slave stream is one timer tick carrying the sampled
// bus level, an arm flag and the 12-byte limit flag. Results leave on the master
// stream: tuser holds the kind (data byte, frame end, no data, bus error), tdata
// the byte and the running byte count. A tick yields zero or one result.
// Config registers are written through cfg_valid_i/cfg_ready_o with an index
// and 16-bit data. The user must write them only while the receiver holds no
// ticks in flight; the block itself does not enforce this.
// Path: a tick is captured in the input register, then decoded into the result
// register, which drives the master stream. A master-side stall can come between.
// Throughput: one tick per cycle while the master side does not stall; the decode
// between the two registers is a single pass, with no loop across cycles.
// Reset: config returns to its defaults, the receiver goes idle and both
// stream registers empty. When the master side stalls, the result register
// holds; the input register keeps taking ticks until it is also full, after
// which s_axis_tready drops.
module vpw_frame_receiver import vpw_rx_pkg::*; #(
  parameter int BUFFER_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [0] bus_active, [1] arm, [2] limit_to_twelve, [7:3] zero
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte, [12:8] frame byte count, [15:13] zero
  output logic [15:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg_q;
  sample_t in_q;
  logic    in_valid_q;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    advance, step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resp_timeout <= 16'd100;
      cfg_q.start_min    <= 16'd163;
      cfg_q.start_max    <= 16'd239;
      cfg_q.pulse_min    <= 16'd34;
      cfg_q.short_max    <= 16'd96;
      cfg_q.long_min     <= 16'd96;
      cfg_q.long_max     <= 16'd163;
      cfg_q.end_min      <= 16'd163;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RESP_TIMEOUT: cfg_q.resp_timeout <= cfg_data_i;
        REG_START_MIN:    cfg_q.start_min    <= cfg_data_i;
        REG_START_MAX:    cfg_q.start_max    <= cfg_data_i;
        REG_PULSE_MIN:    cfg_q.pulse_min    <= cfg_data_i;
        REG_SHORT_MAX:    cfg_q.short_max    <= cfg_data_i;
        REG_LONG_MIN:     cfg_q.long_min     <= cfg_data_i;
        REG_LONG_MAX:     cfg_q.long_max     <= cfg_data_i;
        REG_END_MIN:      cfg_q.end_min      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // result register can take a new value when empty or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.bus_active      <= s_axis_tdata[0];
      in_q.arm             <= s_axis_tdata[1];
      in_q.limit_to_twelve <= s_axis_tdata[2];
    end
  end

  vpw_rx_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .sample_i(in_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {3'd0, out_q.frame_bytes, out_q.data_byte};

endmodule
